// File: src/deqr_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the double-ended queue: operation and status codes
// and the command and status structs between controller and datapath.
// No dependencies.
package deqr_pkg;

    localparam int OP_W  = 3;
    localparam int STS_W = 2;
    localparam int VAL_W = 64;

    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
    localparam logic [OP_W-1:0] OP_REVERSE    = 3'd2;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd3;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd4;

    localparam logic [STS_W-1:0] ST_POPPED = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic accept;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic needs_result;
        logic out_free;
    } dp_stat_t;

endpackage

// File: src/deqr_in_if.sv
`timescale 1ns / 1ps
// Input channel of the queue: one beat carries an operation and a value.
// Depends on deqr_pkg.
interface deqr_in_if;

    logic                                valid;
    logic                                ready;
    logic [deqr_pkg::OP_W-1:0]           operation;
    logic signed [deqr_pkg::VAL_W-1:0]   value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);

endinterface

// File: src/deqr_out_if.sv
`timescale 1ns / 1ps
// Result channel of the queue: one beat carries a status and a value.
// Depends on deqr_pkg.
interface deqr_out_if;

    logic                                valid;
    logic                                ready;
    logic [deqr_pkg::STS_W-1:0]          status;
    logic signed [deqr_pkg::VAL_W-1:0]   result_value;

    modport source (output valid, output status, output result_value, input ready);
    modport sink   (input valid, input status, input result_value, output ready);

endinterface

// File: src/deqr_ctrl.sv
`timescale 1ns / 1ps
// Controller of the queue: takes input beats and sequences result delivery.
// Depends on deqr_pkg.
module deqr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  deqr_pkg::dp_stat_t   stat,
    output deqr_pkg::ctl_cmd_t   cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_RESULT = 1'b1;

    logic state_reg;
    logic state_next;

    assign req_ready    = (state_reg == S_IDLE);
    assign cmd.accept   = req_valid && req_ready;
    assign cmd.load_out = (state_reg == S_RESULT) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept && stat.needs_result)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/deqr_dp.sv
`timescale 1ns / 1ps
// Datapath of the queue: slot memory, head pointer, count, direction flag
// and the result register. Depends on deqr_pkg.
module deqr_dp #(
    parameter int DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [deqr_pkg::OP_W-1:0]          operation,
    input  logic signed [deqr_pkg::VAL_W-1:0]  value,
    input  deqr_pkg::ctl_cmd_t                 cmd,
    output deqr_pkg::dp_stat_t                 stat,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic [deqr_pkg::STS_W-1:0]         rsp_status,
    output logic signed [deqr_pkg::VAL_W-1:0]  rsp_result_value
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

    logic [deqr_pkg::VAL_W-1:0]        mem [DEPTH];
    logic [deqr_pkg::VAL_W-1:0]        rd_data_reg;
    logic [AW-1:0]                     head_reg;
    logic [AW-1:0]                     head_next;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic                              rev_reg;
    logic                              rev_next;
    logic [deqr_pkg::STS_W-1:0]        pend_reg;
    logic [deqr_pkg::STS_W-1:0]        pend_next;
    logic                              out_valid_reg;
    logic [deqr_pkg::STS_W-1:0]        out_status_reg;
    logic signed [deqr_pkg::VAL_W-1:0] out_value_reg;

    logic          is_empty;
    logic          is_full;
    logic          use_low;
    logic          needs_result;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_last;
    logic [AW-1:0] tail_addr;
    logic [AW-1:0] last_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_CNT);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);

    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_last = tail_sum - SW'(1);
    assign tail_addr = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : AW'(tail_sum);
    assign last_addr = (tail_last >= DEPTH_SUM) ? AW'(tail_last - DEPTH_SUM)
                                                : AW'(tail_last);

    // A front operation works on the low side unless the queue is reversed.
    assign use_low = ((operation == deqr_pkg::OP_POP_FRONT) ||
                      (operation == deqr_pkg::OP_PUSH_FRONT)) ? !rev_reg : rev_reg;

    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        rev_next     = rev_reg;
        pend_next    = pend_reg;
        wr_en        = 1'b0;
        wr_addr      = use_low ? head_dec : tail_addr;
        rd_en        = 1'b0;
        rd_addr      = use_low ? head_reg : last_addr;
        needs_result = 1'b0;
        case (operation)
            deqr_pkg::OP_POP_BACK, deqr_pkg::OP_POP_FRONT:
            begin
                needs_result = 1'b1;
                if (cmd.accept)
                begin
                    if (is_empty)
                    begin
                        pend_next = deqr_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        pend_next  = deqr_pkg::ST_POPPED;
                        rd_en      = 1'b1;
                        count_next = count_reg - CW'(1);
                        if (use_low)
                        begin
                            head_next = head_inc;
                        end
                    end
                end
            end
            deqr_pkg::OP_REVERSE:
            begin
                if (cmd.accept)
                begin
                    rev_next = !rev_reg;
                end
            end
            deqr_pkg::OP_PUSH_BACK, deqr_pkg::OP_PUSH_FRONT:
            begin
                needs_result = is_full;
                if (cmd.accept)
                begin
                    if (is_full)
                    begin
                        pend_next = deqr_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (use_low)
                        begin
                            head_next = head_dec;
                        end
                    end
                end
            end
            default:
            begin
                needs_result = 1'b0;
            end
        endcase
    end

    assign stat.needs_result = needs_result;
    assign stat.out_free     = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (cmd.load_out)
        begin
            out_status_reg <= pend_reg;
            out_value_reg  <= (pend_reg == deqr_pkg::ST_POPPED) ? rd_data_reg : '0;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_status       = out_status_reg;
    assign rsp_result_value = out_value_reg;

    // The count never goes beyond the capacity of the slot memory.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("item count exceeds capacity");

    // A push into a full queue leaves the count unchanged.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && is_full && ((operation == deqr_pkg::OP_PUSH_BACK) ||
                                   (operation == deqr_pkg::OP_PUSH_FRONT)))
        |=> (count_reg == FULL_CNT))
        else $error("push into full queue changed the count");

    // A pop from an empty queue never reports a popped value.
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && is_empty && ((operation == deqr_pkg::OP_POP_BACK) ||
                                    (operation == deqr_pkg::OP_POP_FRONT)))
        |=> (pend_reg == deqr_pkg::ST_EMPTY) && (count_reg == '0))
        else $error("pop from empty queue not reported as empty");

    // Loading a result always presents a beat on the next cycle.
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// File: src/double_ended_queue_with_reverse.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 64-bit values with reversal.
// Channel req carries an operation and a value, channel rsp a status and a value.
// Pops always produce one rsp beat; a push into a full queue produces a full
// status beat and is dropped; successful pushes, reverse and unused codes
// produce no beat.
// A new beat is taken in every cycle while no result waits to be loaded into
// the rsp register. An operation with a result holds req.ready low while the
// slot memory read completes and until its beat is loaded; that beat passes
// the read data register, then the rsp register.
// The rsp register holds a finished beat while the receiver stalls; req.ready
// stays high meanwhile for operations that produce no result.
// Reset empties the queue and restores normal orientation at once; there is
// no clearing pass, and slot contents are undefined until written.
// Depends on deqr_pkg, deqr_in_if, deqr_out_if, deqr_ctrl and deqr_dp.
module double_ended_queue_with_reverse #(
    parameter int DEPTH = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    deqr_in_if.sink    req,
    deqr_out_if.source rsp
);

    deqr_pkg::ctl_cmd_t cmd;
    deqr_pkg::dp_stat_t stat;

    deqr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    deqr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .operation        (req.operation),
        .value            (req.value),
        .cmd              (cmd),
        .stat             (stat),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_status       (rsp.status),
        .rsp_result_value (rsp.result_value)
    );

endmodule
